// File: rtl/bfet_pkg.sv
// Shared constants, codes and types of the budgeted FIFO eviction table.
package bfet_pkg;

    localparam int DEFAULT_DEPTH    = 16;
    localparam int DEFAULT_TAG_BITS = 32;

    localparam int KEY_PORT_W = 32;
    localparam int HANDLE_W   = 32;
    localparam int DIM_W      = 15;
    localparam int SIZE_W     = 31;
    localparam int SEQ_W      = 32;
    localparam int RES_W      = 35;
    localparam int MB_W       = 11;
    localparam int MB_SHIFT   = 20;
    localparam int CACHE_MB_W = RES_W - MB_SHIFT;

    localparam logic [DIM_W-1:0] DIM_MAX  = 15'd16384;
    localparam logic [MB_W-1:0]  MB_RESET = 11'd256;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_LOOKUP = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_TRIM   = 3'd4;

    localparam logic RK_DONE  = 1'b0;
    localparam logic RK_EVICT = 1'b1;

    typedef enum logic {
        CMP_MATCH,
        CMP_OLDEST
    } cmp_mode_t;

    typedef struct packed {
        logic      clear;
        logic      step;
        cmp_mode_t mode;
    } cmp_ctl_t;

endpackage

// File: rtl/bfet_store.sv
// Entry memories of the table: key, handle, size and sequence, one read and one write port.
module bfet_store
    import bfet_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH,
    parameter int KEY_W       = DEFAULT_TAG_BITS,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [IDX_W-1:0]    waddr,
    input  logic [KEY_W-1:0]    wkey,
    input  logic [HANDLE_W-1:0] whandle,
    input  logic [SIZE_W-1:0]   wbytes,
    input  logic [SEQ_W-1:0]    wseq,
    input  logic [IDX_W-1:0]    raddr,
    output logic [KEY_W-1:0]    rkey,
    output logic [HANDLE_W-1:0] rhandle,
    output logic [SIZE_W-1:0]   rbytes,
    output logic [SEQ_W-1:0]    rseq
);

    logic [KEY_W-1:0]    key_mem    [TABLE_DEPTH];
    logic [HANDLE_W-1:0] handle_mem [TABLE_DEPTH];
    logic [SIZE_W-1:0]   bytes_mem  [TABLE_DEPTH];
    logic [SEQ_W-1:0]    seq_mem    [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]    <= wkey;
            handle_mem[waddr] <= whandle;
            bytes_mem[waddr]  <= wbytes;
            seq_mem[waddr]    <= wseq;
        end
        rkey    <= key_mem[raddr];
        rhandle <= handle_mem[raddr];
        rbytes  <= bytes_mem[raddr];
        rseq    <= seq_mem[raddr];
    end

endmodule

// File: rtl/bfet_cmp.sv
// Shared compare unit: finds the first key match or the oldest valid entry over a scan.
module bfet_cmp
    import bfet_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH,
    parameter int KEY_W       = DEFAULT_TAG_BITS,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmp_ctl_t         ctl,
    input  logic [IDX_W-1:0] idx,
    input  logic             entry_valid,
    input  logic [KEY_W-1:0] entry_key,
    input  logic [SEQ_W-1:0] entry_seq,
    input  logic [KEY_W-1:0] search_key,
    output logic             found,
    output logic [IDX_W-1:0] best_idx
);

    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic             take;

    always_comb
    begin
        take = 1'b0;
        if (ctl.step && entry_valid)
        begin
            if (ctl.mode == CMP_MATCH)
                take = !found_reg && (entry_key == search_key);
            else
                take = !found_reg || (entry_seq < seq_reg);
        end
        found_next = found_reg;
        idx_next   = idx_reg;
        seq_next   = seq_reg;
        if (ctl.clear)
            found_next = 1'b0;
        else if (take)
        begin
            found_next = 1'b1;
            idx_next   = idx;
            seq_next   = entry_seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
            seq_reg   <= seq_next;
        end
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;

endmodule

// File: rtl/budgeted_fifo_eviction_table.sv
// Top level: request sequencer, valid bits, byte accounting and result register.
//
// Usage: software raises start with a request (kind, key_tag, image_width,
// image_height, new_handle) while busy is low; the item is taken at that edge
// and busy stays high until its work is done. Results appear on result_kind,
// handle, hit, cache_mb and last for exactly one cycle each, marked by
// result_valid; the receiver must take them, it cannot stall the block.
// Eviction notices come first and the completion, with last set, ends the item.
// The byte budget in mebibytes is written through cfg_wr_en / cfg_wr_data
// while the block is idle; it resets to 256 MiB.
// Every table search sweeps the entry memory through one read port and one
// compare unit. A lookup, delete or insert first searches for its key; an
// insert miss then sizes the entry, evicts the oldest entries to fit the
// budget, evicts one more if the table is full, and stores the entry. A
// clear sweeps every slot, and a trim evicts the oldest entries until the
// budget is met. Reset clears all valid bits, the byte count and the
// sequence counter; the entry memories need no clearing pass.
module budgeted_fifo_eviction_table
    import bfet_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH,
    parameter int TAG_BITS    = DEFAULT_TAG_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            kind,
    input  logic [KEY_PORT_W-1:0] key_tag,
    input  logic [DIM_W-1:0]      image_width,
    input  logic [DIM_W-1:0]      image_height,
    input  logic [HANDLE_W-1:0]   new_handle,
    input  logic                  cfg_wr_en,
    input  logic [MB_W-1:0]       cfg_wr_data,
    output logic                  result_valid,
    output logic                  result_kind,
    output logic [HANDLE_W-1:0]   handle,
    output logic                  hit,
    output logic [CACHE_MB_W-1:0] cache_mb,
    output logic                  last
);

    localparam int KEY_W = (TAG_BITS < KEY_PORT_W) ? TAG_BITS : KEY_PORT_W;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KSCAN,
        ST_KPICK,
        ST_KRES,
        ST_SIZE,
        ST_FIT,
        ST_OSCAN,
        ST_EPICK,
        ST_EDROP,
        ST_STORE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [RES_W-1:0]        resident_reg, resident_next;
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic [MB_W-1:0]         budget_reg, budget_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    full_reg, full_next;
    logic [HANDLE_W-1:0]     comp_handle_reg, comp_handle_next;
    logic                    comp_hit_reg, comp_hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    logic [HANDLE_W-1:0]     out_handle_reg, out_handle_next;
    logic                    out_hit_reg, out_hit_next;
    logic [CACHE_MB_W-1:0]   out_mb_reg, out_mb_next;
    logic                    out_last_reg, out_last_next;

    // Request payload, held for the whole item.
    logic [2:0]              kind_q;
    logic [KEY_W-1:0]        key_q;
    logic [DIM_W-1:0]        width_q;
    logic [DIM_W-1:0]        height_q;
    logic [HANDLE_W-1:0]     nh_q;

    logic                    accept;
    logic [IDX_W-1:0]        raddr;
    logic                    mem_we;
    logic [IDX_W-1:0]        free_idx;
    logic [KEY_W-1:0]        rd_key;
    logic [HANDLE_W-1:0]     rd_handle;
    logic [SIZE_W-1:0]       rd_bytes;
    logic [SEQ_W-1:0]        rd_seq;
    cmp_ctl_t                ctl;
    logic                    cmp_found;
    logic [IDX_W-1:0]        cmp_idx;
    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        prev_idx;
    logic                    cnt_last;
    logic [DIM_W-1:0]        width_sat;
    logic [DIM_W-1:0]        height_sat;
    logic [2*DIM_W-1:0]      product;
    logic [RES_W-1:0]        res_sub;
    logic [RES_W:0]          res_with_new;
    logic [RES_W:0]          budget_bytes;
    logic                    over_budget;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign prev_idx = cnt_m1[IDX_W-1:0];
    assign cnt_last = (cnt_reg == CNT_END);

    assign width_sat  = (width_q > DIM_MAX) ? DIM_MAX : width_q;
    assign height_sat = (height_q > DIM_MAX) ? DIM_MAX : height_q;
    assign product    = (2*DIM_W)'(width_sat) * (2*DIM_W)'(height_sat);

    assign res_sub      = resident_reg - RES_W'(rd_bytes);
    assign res_with_new = {1'b0, resident_reg} + (RES_W + 1)'(size_reg);
    assign budget_bytes = (RES_W + 1)'({budget_reg, {MB_SHIFT{1'b0}}});
    assign over_budget  = res_with_new > budget_bytes;

    // Lowest free slot; only used when at least one slot is free.
    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    bfet_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (free_idx),
        .wkey    (key_q),
        .whandle (nh_q),
        .wbytes  (size_reg),
        .wseq    (seq_reg),
        .raddr   (raddr),
        .rkey    (rd_key),
        .rhandle (rd_handle),
        .rbytes  (rd_bytes),
        .rseq    (rd_seq)
    );

    bfet_cmp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_W       (KEY_W),
        .IDX_W       (IDX_W)
    ) u_cmp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .idx         (prev_idx),
        .entry_valid (valid_reg[prev_idx]),
        .entry_key   (rd_key),
        .entry_seq   (rd_seq),
        .search_key  (key_q),
        .found       (cmp_found),
        .best_idx    (cmp_idx)
    );

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        resident_next    = resident_reg;
        seq_next         = seq_reg;
        budget_next      = cfg_wr_en ? cfg_wr_data : budget_reg;
        size_next        = size_reg;
        cnt_next         = cnt_reg;
        full_next        = full_reg;
        comp_handle_next = comp_handle_reg;
        comp_hit_next    = comp_hit_reg;
        out_valid_next   = 1'b0;
        out_kind_next    = out_kind_reg;
        out_handle_next  = out_handle_reg;
        out_hit_next     = out_hit_reg;
        out_mb_next      = out_mb_reg;
        out_last_next    = out_last_reg;
        ctl              = '{clear: 1'b0, step: 1'b0, mode: CMP_MATCH};
        raddr            = cnt_reg[IDX_W-1:0];
        mem_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next         = '0;
                    size_next        = '0;
                    comp_handle_next = '0;
                    comp_hit_next    = 1'b0;
                    unique case (kind) inside
                        KIND_INSERT, KIND_LOOKUP, KIND_DELETE: state_next = ST_KSCAN;
                        KIND_CLEAR:                            state_next = ST_CLEAR;
                        KIND_TRIM:                             state_next = ST_FIT;
                        default:                               state_next = ST_DONE;
                    endcase
                end
            end

            ST_KSCAN, ST_OSCAN:
            begin
                ctl.mode  = (state_reg == ST_KSCAN) ? CMP_MATCH : CMP_OLDEST;
                ctl.clear = (cnt_reg == '0);
                ctl.step  = (cnt_reg != '0);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_last)
                    state_next = (state_reg == ST_KSCAN) ? ST_KPICK : ST_EPICK;
            end

            ST_KPICK:
            begin
                raddr      = cmp_idx;
                state_next = ST_KRES;
            end

            ST_KRES:
            begin
                state_next = ST_DONE;
                case (kind_q)
                    KIND_INSERT:
                    begin
                        if (cmp_found)
                        begin
                            comp_handle_next = rd_handle;
                            comp_hit_next    = 1'b1;
                        end
                        else
                            state_next = ST_SIZE;
                    end
                    KIND_LOOKUP:
                    begin
                        comp_handle_next = cmp_found ? rd_handle : '0;
                        comp_hit_next    = cmp_found;
                    end
                    default:
                    begin
                        // Delete: a present key leaves with a notice first.
                        comp_hit_next = cmp_found;
                        if (cmp_found)
                        begin
                            valid_next[cmp_idx] = 1'b0;
                            resident_next       = res_sub;
                            out_valid_next      = 1'b1;
                            out_kind_next       = RK_EVICT;
                            out_handle_next     = rd_handle;
                            out_hit_next        = 1'b0;
                            out_mb_next         = res_sub[RES_W-1:MB_SHIFT];
                            out_last_next       = 1'b0;
                        end
                    end
                endcase
            end

            ST_SIZE:
            begin
                size_next  = {product[SIZE_W-3:0], 2'b00};
                state_next = ST_FIT;
            end

            ST_FIT:
            begin
                cnt_next = '0;
                if (over_budget && (valid_reg != '0))
                begin
                    full_next  = 1'b0;
                    state_next = ST_OSCAN;
                end
                else if (kind_q == KIND_INSERT)
                begin
                    if (&valid_reg)
                    begin
                        full_next  = 1'b1;
                        state_next = ST_OSCAN;
                    end
                    else
                        state_next = ST_STORE;
                end
                else
                    state_next = ST_DONE;
            end

            ST_EPICK:
            begin
                raddr      = cmp_idx;
                state_next = ST_EDROP;
            end

            ST_EDROP:
            begin
                valid_next[cmp_idx] = 1'b0;
                resident_next       = res_sub;
                out_valid_next      = 1'b1;
                out_kind_next       = RK_EVICT;
                out_handle_next     = rd_handle;
                out_hit_next        = 1'b0;
                out_mb_next         = res_sub[RES_W-1:MB_SHIFT];
                out_last_next       = 1'b0;
                state_next          = full_reg ? ST_STORE : ST_FIT;
            end

            ST_STORE:
            begin
                mem_we               = 1'b1;
                valid_next[free_idx] = 1'b1;
                resident_next        = res_with_new[RES_W-1:0];
                seq_next             = seq_reg + SEQ_W'(1);
                comp_handle_next     = nh_q;
                comp_hit_next        = 1'b0;
                state_next           = ST_DONE;
            end

            ST_CLEAR:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if ((cnt_reg != '0) && valid_reg[prev_idx])
                begin
                    valid_next[prev_idx] = 1'b0;
                    resident_next        = res_sub;
                    out_valid_next       = 1'b1;
                    out_kind_next        = RK_EVICT;
                    out_handle_next      = rd_handle;
                    out_hit_next         = 1'b0;
                    out_mb_next          = res_sub[RES_W-1:MB_SHIFT];
                    out_last_next        = 1'b0;
                end
                if (cnt_last)
                begin
                    resident_next = '0;
                    state_next    = ST_DONE;
                end
            end

            ST_DONE:
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = RK_DONE;
                out_handle_next = comp_handle_reg;
                out_hit_next    = comp_hit_reg;
                out_mb_next     = resident_reg[RES_W-1:MB_SHIFT];
                out_last_next   = 1'b1;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            resident_reg    <= '0;
            seq_reg         <= '0;
            budget_reg      <= MB_RESET;
            size_reg        <= '0;
            cnt_reg         <= '0;
            full_reg        <= 1'b0;
            comp_handle_reg <= '0;
            comp_hit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= RK_DONE;
            out_handle_reg  <= '0;
            out_hit_reg     <= 1'b0;
            out_mb_reg      <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            resident_reg    <= resident_next;
            seq_reg         <= seq_next;
            budget_reg      <= budget_next;
            size_reg        <= size_next;
            cnt_reg         <= cnt_next;
            full_reg        <= full_next;
            comp_handle_reg <= comp_handle_next;
            comp_hit_reg    <= comp_hit_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_handle_reg  <= out_handle_next;
            out_hit_reg     <= out_hit_next;
            out_mb_reg      <= out_mb_next;
            out_last_reg    <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_q   <= kind;
            key_q    <= key_tag[KEY_W-1:0];
            width_q  <= image_width;
            height_q <= image_height;
            nh_q     <= new_handle;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign handle       = out_handle_reg;
    assign hit          = out_hit_reg;
    assign cache_mb     = out_mb_reg;
    assign last         = out_last_reg;

endmodule

// File: verif/testbench.sv
// Self-checking testbench: directed and random requests against a built-in table predictor.
module testbench;
    import bfet_pkg::*;

    localparam int DEPTH           = DEFAULT_DEPTH;
    localparam int SUM_W           = RES_W + 1;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int KEY_POOL        = 24;
    localparam int TAIL_CYCLES     = 4 * (DEPTH + 4);
    localparam int CYCLE_LIMIT     = 2_000_000;

    localparam logic [2:0] KIND_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [2:0]            kind;
        logic [KEY_PORT_W-1:0] key;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
        logic [HANDLE_W-1:0]   nh;
    } request_t;

    typedef struct packed {
        logic                  rk;
        logic [HANDLE_W-1:0]   handle;
        logic                  hit;
        logic [CACHE_MB_W-1:0] mb;
        logic                  last;
    } result_t;

    typedef struct packed {
        request_t              req;
        logic                  typed;
        logic [HANDLE_W-1:0]   handle;
        logic                  hit;
        logic [CACHE_MB_W-1:0] mb;
    } row_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [2:0]            kind         = KIND_INSERT;
    logic [KEY_PORT_W-1:0] key_tag      = '0;
    logic [DIM_W-1:0]      image_width  = '0;
    logic [DIM_W-1:0]      image_height = '0;
    logic [HANDLE_W-1:0]   new_handle   = '0;
    logic                  cfg_wr_en    = 1'b0;
    logic [MB_W-1:0]       cfg_wr_data  = '0;
    logic                  result_valid;
    logic                  result_kind;
    logic [HANDLE_W-1:0]   handle;
    logic                  hit;
    logic [CACHE_MB_W-1:0] cache_mb;
    logic                  last;

    // Predicted contents of the table.
    logic                  entry_valid [DEPTH];
    logic [KEY_PORT_W-1:0] entry_key   [DEPTH];
    logic [HANDLE_W-1:0]   entry_handle[DEPTH];
    logic [SIZE_W-1:0]     entry_bytes [DEPTH];
    logic [SEQ_W-1:0]      entry_seq   [DEPTH];
    logic [RES_W-1:0]      resident_bytes = '0;
    logic [SEQ_W-1:0]      seq_next       = '0;
    logic [MB_W-1:0]       budget_mb      = MB_RESET;

    result_t               expected_results[$];
    row_t                  directed_rows[$];
    logic [KEY_PORT_W-1:0] key_pool[KEY_POOL];
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    budgeted_fifo_eviction_table i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .key_tag      (key_tag),
        .image_width  (image_width),
        .image_height (image_height),
        .new_handle   (new_handle),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .handle       (handle),
        .hit          (hit),
        .cache_mb     (cache_mb),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string text);
        $display("mismatch at cycle %0d: %s", cycle_count, text);
        mismatch_count++;
    endtask

    function automatic void push_result(logic rk, logic [HANDLE_W-1:0] h, logic hit_bit,
                                        logic last_bit);
        result_t r;
        r.rk     = rk;
        r.handle = h;
        r.hit    = hit_bit;
        r.mb     = resident_bytes[RES_W-1:MB_SHIFT];
        r.last   = last_bit;
        expected_results.push_back(r);
    endfunction

    function automatic void evict_entry(int i);
        entry_valid[i] = 1'b0;
        resident_bytes = resident_bytes - RES_W'(entry_bytes[i]);
        push_result(RK_EVICT, entry_handle[i], 1'b0, 1'b0);
    endfunction

    // Age is the insertion sequence number; ties go to the lowest slot.
    function automatic void evict_oldest_entry();
        int oldest;
        oldest = -1;
        for (int i = 0; i < DEPTH; i++)
            if (entry_valid[i] && (oldest < 0 || entry_seq[i] < entry_seq[oldest]))
                oldest = i;
        if (oldest >= 0)
            evict_entry(oldest);
    endfunction

    function automatic int find_entry(logic [KEY_PORT_W-1:0] key);
        for (int i = 0; i < DEPTH; i++)
            if (entry_valid[i] && entry_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int live_entries();
        int count;
        count = 0;
        for (int i = 0; i < DEPTH; i++)
            if (entry_valid[i])
                count++;
        return count;
    endfunction

    function automatic void predict_table_request(request_t r);
        int                s;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [SIZE_W-1:0] bytes;
        logic [SUM_W-1:0]  budget;
        budget = SUM_W'(budget_mb) << MB_SHIFT;
        case (r.kind)
            KIND_INSERT:
            begin
                s = find_entry(r.key);
                if (s >= 0)
                    push_result(RK_DONE, entry_handle[s], 1'b1, 1'b1);
                else
                begin
                    w = (r.w > DIM_MAX) ? DIM_MAX : r.w;
                    h = (r.h > DIM_MAX) ? DIM_MAX : r.h;
                    bytes = SIZE_W'(w) * SIZE_W'(h) * SIZE_W'(BYTES_PER_PIXEL);
                    while (SUM_W'(resident_bytes) + SUM_W'(bytes) > budget && live_entries() > 0)
                        evict_oldest_entry();
                    if (live_entries() >= DEPTH)
                        evict_oldest_entry();
                    s = 0;
                    while (s < DEPTH && entry_valid[s])
                        s++;
                    entry_valid[s]  = 1'b1;
                    entry_key[s]    = r.key;
                    entry_handle[s] = r.nh;
                    entry_bytes[s]  = bytes;
                    entry_seq[s]    = seq_next;
                    seq_next        = seq_next + SEQ_W'(1);
                    resident_bytes  = resident_bytes + RES_W'(bytes);
                    push_result(RK_DONE, r.nh, 1'b0, 1'b1);
                end
            end
            KIND_LOOKUP:
            begin
                s = find_entry(r.key);
                push_result(RK_DONE, (s >= 0) ? entry_handle[s] : '0, s >= 0, 1'b1);
            end
            KIND_DELETE:
            begin
                s = find_entry(r.key);
                if (s >= 0)
                    evict_entry(s);
                push_result(RK_DONE, '0, s >= 0, 1'b1);
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (entry_valid[i])
                        evict_entry(i);
                resident_bytes = '0;
                push_result(RK_DONE, '0, 1'b0, 1'b1);
            end
            KIND_TRIM:
            begin
                while (SUM_W'(resident_bytes) > budget && live_entries() > 0)
                    evict_oldest_entry();
                push_result(RK_DONE, '0, 1'b0, 1'b1);
            end
            default:
                push_result(RK_DONE, '0, 1'b0, 1'b1);
        endcase
    endfunction

    task automatic compare_result(input result_t got, input result_t want);
        if (got.rk !== want.rk)
            report_mismatch($sformatf("result_kind %0b, expected %0b", got.rk, want.rk));
        if (got.handle !== want.handle)
            report_mismatch($sformatf("handle %h, expected %h", got.handle, want.handle));
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
        if (got.mb !== want.mb)
            report_mismatch($sformatf("cache_mb %0d, expected %0d", got.mb, want.mb));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    always @(posedge clk)
    begin : take_results
        result_t got;
        result_t want;
        if (rst_n && result_valid)
        begin
            got.rk     = result_kind;
            got.handle = handle;
            got.hit    = hit;
            got.mb     = cache_mb;
            got.last   = last;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result, handle %h", handle));
            else
            begin
                want = expected_results.pop_front();
                compare_result(got, want);
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic issue_request(input request_t r);
        start        <= 1'b1;
        kind         <= r.kind;
        key_tag      <= r.key;
        image_width  <= r.w;
        image_height <= r.h;
        new_handle   <= r.nh;
        do
            @(posedge clk);
        while (busy);
        predict_table_request(r);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sampling on the falling edge keeps the decision clear of the result monitor.
    task automatic wait_until_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0 || busy);
        @(posedge clk);
    endtask

    task automatic write_budget(input logic [MB_W-1:0] mb);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mb;
        @(posedge clk);
        budget_mb = mb;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void add_row(logic [2:0] k, logic [KEY_PORT_W-1:0] key,
                                    logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                    logic [HANDLE_W-1:0] nh, logic typed,
                                    logic [HANDLE_W-1:0] h_want, logic hit_want,
                                    logic [CACHE_MB_W-1:0] mb_want);
        row_t r;
        r.req.kind = k;
        r.req.key  = key;
        r.req.w    = w;
        r.req.h    = h;
        r.req.nh   = nh;
        r.typed    = typed;
        r.handle   = h_want;
        r.hit      = hit_want;
        r.mb       = mb_want;
        directed_rows.push_back(r);
    endfunction

    // Mostly small images so that many entries fit; a few raw values saturate.
    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0:       return DIM_W'($urandom_range(0, 32767));
            1:       return '0;
            default: return DIM_W'($urandom_range(1, 1 << $urandom_range(0, 12)));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t q;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 48)
            q.kind = KIND_INSERT;
        else if (pick < 68)
            q.kind = KIND_LOOKUP;
        else if (pick < 82)
            q.kind = KIND_DELETE;
        else if (pick < 85)
            q.kind = KIND_CLEAR;
        else if (pick < 93)
            q.kind = KIND_TRIM;
        else
            q.kind = 3'($urandom_range(KIND_TRIM + 1, KIND_SPARE_LAST));
        q.key = ($urandom_range(0, 4) == 0) ? KEY_PORT_W'($urandom)
                                            : key_pool[$urandom_range(0, KEY_POOL - 1)];
        q.w  = random_dim();
        q.h  = random_dim();
        q.nh = $urandom;
        return q;
    endfunction

    initial
    begin : stimulus
        row_t            r;
        request_t        q;
        result_t         done;
        bit              idle_on;
        logic [MB_W-1:0] mb;

        for (int i = 0; i < DEPTH; i++)
            entry_valid[i] = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // Empty table: misses, an idle trim and an unused kind.
        add_row(KIND_LOOKUP, 32'h0000_0000, 0, 0, 0, 1'b1, 32'h0, 1'b0, 0);
        add_row(KIND_DELETE, 32'hFFFF_FFFF, 0, 0, 0, 1'b1, 32'h0, 1'b0, 0);
        add_row(KIND_TRIM, 32'h0000_0001, 0, 0, 0, 1'b1, 32'h0, 1'b0, 0);
        add_row(KIND_SPARE_LAST, 32'h0000_0001, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF,
                1'b1, 32'h0, 1'b0, 0);
        // Zero-sized entry, then a hit that must keep the stored handle.
        add_row(KIND_INSERT, 32'h0000_0001, 0, 0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 0);
        add_row(KIND_INSERT, 32'h0000_0001, 5, 5, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF, 1'b1, 0);
        // Oversized entries are stored after the table empties; dimensions saturate.
        add_row(KIND_INSERT, 32'h0000_0002, 16384, 16384, 32'hA5A5_A5A5,
                1'b1, 32'hA5A5_A5A5, 1'b0, 1024);
        add_row(KIND_INSERT, 32'h0000_0003, 15'h7FFF, 15'h7FFF, 32'h5A5A_5A5A,
                1'b1, 32'h5A5A_5A5A, 1'b0, 1024);
        // Fill every slot with 1 MiB entries, then force a full-table eviction.
        for (int i = 0; i < DEPTH + 1; i++)
            add_row(KIND_INSERT, 32'h8000_0000 | i, 512, 512, 32'hC000_0000 + i, 1'b0, 0, 0, 0);
        add_row(KIND_DELETE, 32'h8000_0005, 0, 0, 0, 1'b0, 0, 0, 0);
        add_row(KIND_CLEAR, 32'h0, 0, 0, 0, 1'b1, 32'h0, 1'b0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            issue_request(r.req);
            if (r.typed)
            begin
                done = expected_results.pop_back();
                done.handle = r.handle;
                done.hit    = r.hit;
                done.mb     = r.mb;
                expected_results.push_back(done);
            end
        end
        wait_until_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       mb = '1;
                1:       mb = '0;
                2:       mb = 11'd1;
                3:       mb = 11'd64;
                5:       mb = MB_RESET;
                6:       mb = MB_W'($urandom_range(8, 512));
                7:       mb = '1;
                default: mb = MB_W'($urandom);
            endcase
            write_budget(mb);
            idle_on = (p < PHASES - 1) && (p % 3 != 2);

            // A lowered budget takes effect through a trim, or when an insert miss evicts to fit.
            q = random_request();
            q.kind = KIND_TRIM;
            issue_request(q);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (idle_on && $urandom_range(0, 5) == 0)
                    pause_sender($urandom_range(1, 11));
                issue_request(random_request());
            end
            wait_until_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
